// ----- rtl/census_transform_5x5_top_assert.svh -----
// Assertion macros used by the census transform top level.
`ifndef CENSUS_TRANSFORM_5X5_TOP_ASSERT_SVH
`define CENSUS_TRANSFORM_5X5_TOP_ASSERT_SVH

// Check that a condition in one cycle brings a consequence in the same cycle.
`define CT5_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("census transform check failed");

// Check that a condition in one cycle brings a consequence in the next cycle.
`define CT5_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("census transform check failed");

`endif

// ----- rtl/ct5_pkg.sv -----
`default_nettype none

package ct5_pkg;

  localparam int PIX_W        = 16;
  localparam int CODE_W       = 24;
  localparam int ROW_W        = 12;
  localparam int CCOL_W       = 11;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int WIN_N        = 5;
  localparam int LINES        = WIN_N - 1;
  localparam int MIN_DIM      = 5;
  localparam int QUEUE_DEPTH  = 2;

  localparam int MAX_LINE_WIDTH_DEF = 2048;

  localparam int OUT_FIELDS_W = CODE_W + ROW_W + CCOL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  typedef logic [PIX_W-1:0] pix_t;

  // One window column with the position of the window center.
  typedef struct packed {
    pix_t [WIN_N-1:0]    column;
    logic                valid;
    logic [ROW_W-1:0]    center_row;
    logic [CCOL_W-1:0]   center_col;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ----- rtl/ct5_front.sv -----
`default_nettype none

module ct5_front #(
  parameter int MAX_LINE_WIDTH = ct5_pkg::MAX_LINE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ct5_pkg::CFG_W-1:0]   line_width,
  input  wire logic [ct5_pkg::CFG_W-1:0]   frame_height,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ct5_pkg::pix_t               pixel_value,
  input  wire logic                        frame_start,
  input  wire ct5_pkg::qstat_t             qstat,
  output logic                             push,
  output ct5_pkg::entry_t                  push_entry
);

  localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
  localparam int CMP_W  = (COL_W + 1 > ct5_pkg::CFG_W) ? COL_W + 1 : ct5_pkg::CFG_W;
  localparam int WORD_W = ct5_pkg::LINES * ct5_pkg::PIX_W;
  localparam int ROW_W  = ct5_pkg::ROW_W;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;

  logic [CMP_W-1:0]  width_eff;
  logic [ROW_W-1:0]  height_eff;
  logic [COL_W-1:0]  col_base, col_cur, col_next;
  logic [ROW_W-1:0]  row_base, row_cur, row_next;
  logic [CMP_W-1:0]  col_inc;
  logic [ROW_W:0]    row_inc;
  logic              accept;

  logic [WORD_W-1:0] line_mem [MAX_LINE_WIDTH];
  logic [WORD_W-1:0] rd_word;

  logic              s1_valid;
  ct5_pkg::pix_t     s1_pix;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic              s1_fwd;
  logic [WORD_W-1:0] s1_fwd_word;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] wr_word;
  logic [CMP_W-1:0]  cc_wide;

  assign push     = s1_valid && !qstat.full;
  assign in_ready = !s1_valid || !qstat.full;
  assign accept   = in_valid && in_ready;

  // Clamp the configured frame size to the supported range.
  always_comb begin
    if (CMP_W'(line_width) < CMP_W'(ct5_pkg::MIN_DIM)) begin
      width_eff = CMP_W'(ct5_pkg::MIN_DIM);
    end else if (CMP_W'(line_width) > CMP_W'(MAX_LINE_WIDTH)) begin
      width_eff = CMP_W'(MAX_LINE_WIDTH);
    end else begin
      width_eff = CMP_W'(line_width);
    end
    height_eff = (frame_height < ROW_W'(ct5_pkg::MIN_DIM)) ? ROW_W'(ct5_pkg::MIN_DIM)
                                                           : frame_height;
  end

  // Raster position of the incoming pixel and of the one after it.
  always_comb begin
    col_base = frame_start ? '0 : column_count;
    row_base = frame_start ? '0 : row_count;
    col_cur  = (CMP_W'(col_base) >= width_eff) ? '0 : col_base;
    row_cur  = (row_base >= height_eff) ? '0 : row_base;
    col_inc  = CMP_W'(col_cur) + CMP_W'(1);
    row_inc  = {1'b0, row_cur} + (ROW_W + 1)'(1);
    if (col_inc >= width_eff) begin
      col_next = '0;
      row_next = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else if (accept) begin
      column_count <= col_next;
      row_count    <= row_next;
      s1_valid     <= 1'b1;
    end else if (push) begin
      s1_valid     <= 1'b0;
    end
  end

  // Capture the pixel; forward the line word being written in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixel_value;
      s1_col      <= col_cur;
      s1_row      <= row_cur;
      s1_fwd      <= push && (s1_col == col_cur);
      s1_fwd_word <= wr_word;
    end
  end

  // Line memory: one read at acceptance, one write as the pixel leaves.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[col_cur];
    end
    if (push) begin
      line_mem[s1_col] <= wr_word;
    end
  end

  always_comb begin
    cur_word = s1_fwd ? s1_fwd_word : rd_word;
    // Shift the column up one line and put the new pixel in the newest line.
    wr_word  = {s1_pix, cur_word[WORD_W-1:ct5_pkg::PIX_W]};
    for (int r = 0; r < ct5_pkg::LINES; r++) begin
      push_entry.column[r] = cur_word[r*ct5_pkg::PIX_W +: ct5_pkg::PIX_W];
    end
    push_entry.column[ct5_pkg::LINES] = s1_pix;
    push_entry.valid = (s1_row >= ROW_W'(4)) && (CMP_W'(s1_col) >= CMP_W'(4));
    push_entry.center_row = (s1_row >= ROW_W'(2)) ? s1_row - ROW_W'(2) : '0;
    cc_wide = (CMP_W'(s1_col) >= CMP_W'(2)) ? CMP_W'(s1_col) - CMP_W'(2) : '0;
    push_entry.center_col = cc_wide[ct5_pkg::CCOL_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/ct5_queue.sv -----
`default_nettype none

module ct5_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ct5_pkg::entry_t  push_entry,
  input  wire logic             pop,
  output ct5_pkg::entry_t       pop_entry,
  output ct5_pkg::qstat_t       qstat
);

  localparam int DEPTH = ct5_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ct5_pkg::entry_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign pop_entry   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ct5_back.sv -----
`default_nettype none

module ct5_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ct5_pkg::entry_t                  entry,
  input  wire ct5_pkg::qstat_t                  qstat,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [ct5_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tuser
);

  localparam int N   = ct5_pkg::WIN_N;
  localparam int MID = N / 2;

  ct5_pkg::pix_t               win      [N][N];
  ct5_pkg::pix_t               win_next [N][N];
  logic [ct5_pkg::CODE_W-1:0]  code;

  logic [ct5_pkg::CODE_W-1:0]  out_code;
  logic                        out_valid;
  logic [ct5_pkg::ROW_W-1:0]   out_row;
  logic [ct5_pkg::CCOL_W-1:0]  out_col;

  assign pop = !qstat.empty && (!m_tvalid || m_tready);

  // Shift the window left and insert the new column on the right.
  always_comb begin
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N - 1; c++) begin
        win_next[r][c] = win[r][c+1];
      end
      win_next[r][N-1] = entry.column[r];
    end
  end

  // Neighbors in row-major order, center skipped, first one in the top bit.
  always_comb begin
    code = '0;
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        if (!(r == MID && c == MID)) begin
          code[ct5_pkg::CODE_W - 1 - (r*N + c - ((r*N + c > MID*N + MID) ? 1 : 0))] =
            (win_next[r][c] < win_next[MID][MID]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_code  <= entry.valid ? code : '0;
      out_valid <= entry.valid;
      out_row   <= entry.center_row;
      out_col   <= entry.center_col;
    end
  end

  assign m_tdata = {(ct5_pkg::OUT_TDATA_W - ct5_pkg::OUT_FIELDS_W)'(0),
                    out_col, out_row, out_code};
  assign m_tuser = out_valid;

endmodule

`default_nettype wire

// ----- rtl/census_transform_5x5_top.sv -----
`default_nettype none

// Streaming 5x5 census transform over 16-bit unsigned pixels in raster order.
// Every accepted pixel yields exactly one output transaction describing the
// window centered two rows and two columns behind it: 24 bits, one per
// neighbor in row-major order with the center skipped, the first neighbor
// in bit 23, a bit set when that neighbor is below the center (unsigned).
// Windows that would cross a frame edge come out with the valid flag clear
// and an all-zero code. Set frame_start (s_tuser) on the first pixel of a
// frame to restart the row and column counters; otherwise they wrap at the
// configured line width (clamped to 5..MAX_LINE_WIDTH) and frame height
// (at least 5). Write the two size registers only while the block is idle.
// Throughput is one pixel per clock sustained while the output is not held
// back: the line memory holds four rows packed into one word per column and
// sees one read (the incoming pixel's column) and one write (the previous
// pixel's column) per pixel, so a simple dual-port memory with one read and
// one write port sets the rate. With no stall the transaction passes the
// pixel register with line read, the queue slot and the output register in
// that order before it is presented. The front end (counters and line
// memory) and the back end (window and compare array) are split by a
// two-entry queue so that each side stalls on its own. The line memory needs
// no clearing pass after reset; the block is ready as soon as reset drops.
module census_transform_5x5_top #(
  parameter int MAX_LINE_WIDTH = ct5_pkg::MAX_LINE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [ct5_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ct5_pkg::CFG_W-1:0]         cfg_data,
  // pixel input
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [ct5_pkg::PIX_W-1:0]         s_tdata,   // [15:0] pixel_value
  input  wire logic                              s_tuser,   // [0] frame_start
  // census output
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [23:0] census_code, [35:24] center_row, [46:36] center_col, [47] zero
  output logic [ct5_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                   m_tuser    // [0] code_valid
);

`include "census_transform_5x5_top_assert.svh"

  logic [ct5_pkg::CFG_W-1:0] line_width;
  logic [ct5_pkg::CFG_W-1:0] frame_height;

  logic             q_push;
  logic             q_pop;
  ct5_pkg::entry_t  q_in;
  ct5_pkg::entry_t  q_out;
  ct5_pkg::qstat_t  q_stat;

  // Hold the frame size; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= ct5_pkg::LINE_WIDTH_RST;
      frame_height <= ct5_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ct5_pkg::CFG_LINE_WIDTH:   line_width   <= cfg_data;
        ct5_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: count raster position, fetch and update the line column.
  ct5_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .line_width   (line_width),
    .frame_height (frame_height),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pixel_value  (s_tdata),
    .frame_start  (s_tuser),
    .qstat        (q_stat),
    .push         (q_push),
    .push_entry   (q_in)
  );

  // Decouple the two halves.
  ct5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .qstat      (q_stat)
  );

  // Back end: advance the window, compare, register the transaction.
  ct5_back u_back (
    .clk      (clk),
    .rst      (rst),
    .entry    (q_out),
    .qstat    (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // An edge window always carries a zero code.
  `CT5_ASSERT_IMPLY(a_edge_code_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[23:0] == 24'd0)
  // A full window has its center at least two rows and two columns in.
  `CT5_ASSERT_IMPLY(a_valid_center, clk, rst, m_tvalid && m_tuser, |m_tdata[35:25] && |m_tdata[46:37])
  // The front end never pushes into a full queue.
  `CT5_ASSERT_IMPLY(a_no_overflow, clk, rst, q_push, !q_stat.full)
  // A pop always leaves an output transaction pending.
  `CT5_ASSERT_NEXT(a_pop_shows, clk, rst, q_pop, m_tvalid)

endmodule

`default_nettype wire

// ----- verif/census_transform_5x5_top_tb.sv -----
`default_nettype none

module census_transform_5x5_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ct5_pkg::*;

  // Register indexes the block has no register for; writes there must do nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  localparam logic [PIX_W-1:0] PIX_MIN    = '0;
  localparam logic [PIX_W-1:0] PIX_MAX    = '1;
  localparam logic [PIX_W-1:0] PIX_MID_LO = PIX_W'(16'h7FFF);
  localparam logic [PIX_W-1:0] PIX_MID_HI = PIX_W'(16'h8000);

  localparam int HOLD_CYCLES  = 300;     // long output back-pressure stretch
  localparam int DRAIN_CYCLES = 8;       // pipeline is three deep; leave margin
  localparam int CYCLE_LIMIT  = 200000;

  // One census output transaction, field by field.
  typedef struct {
    logic [CODE_W-1:0] code;
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [CCOL_W-1:0] col;
  } census_result_t;

  // Tracks the line memory, the window and the raster position, and keeps the
  // census results still owed by the block, oldest first.
  class census_code_tracker;
    logic [PIX_W-1:0] line_mem [LINES][MAX_LINE_WIDTH_DEF];
    logic [PIX_W-1:0] win [WIN_N][WIN_N];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    int unsigned      width_reg;
    int unsigned      height_reg;
    census_result_t   owed_codes[$];
    int               errors;

    function new();
      int r;
      int c;
      for (r = 0; r < LINES; r++)
        for (c = 0; c < MAX_LINE_WIDTH_DEF; c++) line_mem[r][c] = '0;
      for (r = 0; r < WIN_N; r++)
        for (c = 0; c < WIN_N; c++) win[r][c] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = LINE_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_LINE_WIDTH) begin
        width_reg = val;
      end else if (idx == CFG_FRAME_HEIGHT) begin
        height_reg = val;
      end
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic frame_start);
      int unsigned      w;
      int unsigned      h;
      int unsigned      row;
      int unsigned      col;
      int               r;
      int               c;
      logic [PIX_W-1:0] column [WIN_N];
      census_result_t   res;

      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_LINE_WIDTH_DEF) w = MAX_LINE_WIDTH_DEF;
      h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;

      if (frame_start) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      row = row_cnt;
      col = col_cnt;

      // Pull the column of the four older rows and push the new pixel down.
      for (r = 0; r < LINES; r++) column[r] = line_mem[r][col];
      column[WIN_N-1] = pix;
      for (r = 0; r < LINES - 1; r++) line_mem[r][col] = line_mem[r+1][col];
      line_mem[LINES-1][col] = pix;

      for (r = 0; r < WIN_N; r++) begin
        for (c = 0; c < WIN_N - 1; c++) win[r][c] = win[r][c+1];
        win[r][WIN_N-1] = column[r];
      end

      res.valid = (row >= 4) && (col >= 4);
      res.code  = '0;
      if (res.valid) begin
        // Row-major walk, center skipped, first neighbor ends up in the MSB.
        for (r = 0; r < WIN_N; r++)
          for (c = 0; c < WIN_N; c++)
            if (!(r == 2 && c == 2)) res.code = {res.code[CODE_W-2:0], win[r][c] < win[2][2]};
      end
      res.row = (row >= 2) ? ROW_W'(row - 2) : '0;
      res.col = (col >= 2) ? CCOL_W'(col - 2) : '0;
      owed_codes.push_back(res);

      col_cnt = col + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = row + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic flag);
      census_result_t want;
      if (owed_codes.size() == 0) begin
        $display("%0t: unexpected census transaction: expected none, actual data %h flag %b",
                 $time, data, flag);
        errors++;
        return;
      end
      want = owed_codes.pop_front();
      if (data[CODE_W-1:0] !== want.code) begin
        $display("%0t: census_code mismatch: expected %h, actual %h",
                 $time, want.code, data[CODE_W-1:0]);
        errors++;
      end
      if (flag !== want.valid) begin
        $display("%0t: code_valid mismatch: expected %b, actual %b", $time, want.valid, flag);
        errors++;
      end
      if (data[CODE_W +: ROW_W] !== want.row) begin
        $display("%0t: center_row mismatch: expected %0d, actual %0d",
                 $time, want.row, data[CODE_W +: ROW_W]);
        errors++;
      end
      if (data[CODE_W + ROW_W +: CCOL_W] !== want.col) begin
        $display("%0t: center_col mismatch: expected %0d, actual %0d",
                 $time, want.col, data[CODE_W + ROW_W +: CCOL_W]);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_codes.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_LINE_WIDTH;
  logic [CFG_W-1:0]       cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [PIX_W-1:0]       s_tdata   = '0;   // [15:0] pixel_value
  logic                   s_tuser   = 1'b0; // [0] frame_start
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // [23:0] census_code, [35:24] center_row, [46:36] center_col, [47] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;          // [0] code_valid

  census_code_tracker tracker = new();

  // Idling knobs for the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Bump hold_req to ask the output side for one long back-pressure stretch.
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  logic [PIX_W-1:0] pix_base = '0;

  census_transform_5x5_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Output side: honor a pending long hold first, else stall at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watch both buses: record each input transaction before checking the output one.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.note_pixel(s_tdata, s_tuser);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
    end
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("census_transform_5x5_top_tb: errors");
      $finish;
    end
  end

  // Offer one pixel, after a random number of idle cycles, and hold it until taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic frame_start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= frame_start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Write both size registers, then poke the two unused indexes with junk.
  // Keep write enable high across the burst and drop it once at the end.
  task automatic program_size(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom());
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    tracker.write_reg(CFG_LINE_WIDTH, width);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    tracker.write_reg(CFG_FRAME_HEIGHT, height);
    cfg_index <= CFG_SPARE_2;
    cfg_data  <= junk;
    @(posedge clk);
    tracker.write_reg(CFG_SPARE_2, junk);
    cfg_index <= CFG_SPARE_3;
    cfg_data  <= ~junk;
    @(posedge clk);
    tracker.write_reg(CFG_SPARE_3, ~junk);
    cfg_we <= 1'b0;
  endtask

  // One phase: new frame size, then a stream that always opens a fresh frame.
  // Random content mixes full-range values, the extremes and a narrow band
  // around a base so that neighbors often tie with the center. A rare
  // frame_start mid-frame restarts the raster on purpose.
  task automatic run_phase(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                           input int n_items, input int send_pct, input int recv_pct,
                           input bit directed, input bit pressure);
    int               i;
    logic [PIX_W-1:0] pix;
    logic             frame_start;
    program_size(width, height);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    pix_base       = PIX_W'($urandom_range(65532));
    for (i = 0; i < n_items; i++) begin
      if (directed) begin
        // One 5x5 frame: center at mid-scale, neighbors at both extremes and
        // on either side of it, so the only valid window mixes 0s and 1s.
        case (i % 4)
          0:       pix = PIX_MIN;
          1:       pix = PIX_MAX;
          2:       pix = PIX_MID_LO;
          default: pix = PIX_MID_HI;
        endcase
        if (i == 12) pix = PIX_MID_HI;
        frame_start = (i == 0);
      end else begin
        case ($urandom_range(3))
          0: pix = PIX_W'($urandom());
          1: begin
            case ($urandom_range(3))
              0:       pix = PIX_MIN;
              1:       pix = PIX_MAX;
              2:       pix = PIX_MID_LO;
              default: pix = PIX_MID_HI;
            endcase
          end
          default: pix = pix_base + PIX_W'($urandom_range(3));
        endcase
        frame_start = (i == 0) || ($urandom_range(59) == 0);
      end
      // Stall the output for a long stretch while pixels keep coming.
      if (pressure && i == n_items / 3) hold_req <= hold_req + 1;
      // Pause input until the block has emptied, then resume.
      if (pressure && i == (2 * n_items) / 3) drain();
      send_pixel(pix, frame_start);
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame at the minimum size; zero registers clamp up to 5x5.
    run_phase(12'd0,    12'd0,    25,    0,  0,  1'b1, 1'b0);
    // Random phases across idling patterns and frame sizes.
    run_phase(12'd7,    12'd6,    280,   0,  0,  1'b0, 1'b0);
    run_phase(12'd5,    12'd5,    220,   48, 0,  1'b0, 1'b0);
    run_phase(12'd13,   12'd9,    280,   0,  48, 1'b0, 1'b0);
    // Widest setting: 4095 clamps to the maximum line width.
    run_phase(12'd4095, 12'd5,    60,    0,  0,  1'b0, 1'b0);
    run_phase(12'd6,    12'd4095, 320,   38, 38, 1'b0, 1'b0);
    run_phase(12'd9,    12'd7,    370,   38, 38, 1'b0, 1'b1);

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("census_transform_5x5_top_tb: clean");
    end else begin
      $display("census_transform_5x5_top_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
